FILE: src/tld_pkg.sv
// Shared constants, codes and types of the terminal line discipline.
package tld_pkg;

   localparam int LINE_DEPTH  = 32;
   localparam int ADDR_W      = $clog2(LINE_DEPTH);
   localparam int BYTE_W      = 8;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 1;

   localparam logic [BYTE_W-1:0] BYTE_NL = 8'h0A;
   localparam logic [BYTE_W-1:0] BYTE_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] BYTE_BS = 8'h08;

   localparam logic CH_TERM = 1'b0;
   localparam logic CH_PROG = 1'b1;

   localparam logic OP_TERM = 1'b0;
   localparam logic OP_PROG = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] REG_ECHO_ENABLE    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_CANONICAL_MODE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OUTPUT_POST    = 2'd2;

   typedef struct packed {
      logic                   write_enable;
      logic [CSR_INDEX_W-1:0] index;
      logic [CSR_DATA_W-1:0]  data;
   } csr_write_type;

   // Command for the back end: what to emit and what to do to the line store.
   typedef struct packed {
      logic              echo;
      logic              echo_cr;
      logic              raw;
      logic              store;
      logic              rel;
      logic [BYTE_W-1:0] data_byte;
      logic [ADDR_W-1:0] addr;
   } cmd_type;

endpackage

FILE: src/tld_req_if.sv
// Input channel: one byte with its origin per transaction.
interface tld_req_if;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic [tld_pkg::BYTE_W-1:0] data_byte;

   modport source(output valid, operation, data_byte, input ready);
   modport sink(input valid, operation, data_byte, output ready);
endinterface

FILE: src/tld_rsp_if.sv
// Result channel: one delivered byte with its destination per transaction.
interface tld_rsp_if;
   logic                       valid;
   logic                       ready;
   logic                       channel;
   logic [tld_pkg::BYTE_W-1:0] out_byte;
   logic                       last_result;

   modport source(output valid, channel, out_byte, last_result, input ready);
   modport sink(input valid, channel, out_byte, last_result, output ready);
endinterface

FILE: src/tld_front.sv
// Front end: accepts bytes, holds the mode registers and line fill, issues commands.
module tld_front (
   input  logic                   clock,
   input  logic                   reset,
   tld_req_if.sink                req_chan,
   input  tld_pkg::csr_write_type csr_write,
   input  logic                   queue_full,
   output logic                   queue_push,
   output tld_pkg::cmd_type       queue_cmd
);
   import tld_pkg::*;

   logic              echo_enable_ff, echo_enable_in;
   logic              canonical_mode_ff, canonical_mode_in;
   logic              output_post_ff, output_post_in;
   logic [ADDR_W-1:0] fill_ff, fill_in;
   logic              accept;
   cmd_type           cmd;

   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;

   always_comb begin
      echo_enable_in    = echo_enable_ff;
      canonical_mode_in = canonical_mode_ff;
      output_post_in    = output_post_ff;
      if (csr_write.write_enable) begin
         unique case (csr_write.index)
            REG_ECHO_ENABLE:    echo_enable_in    = csr_write.data[0];
            REG_CANONICAL_MODE: canonical_mode_in = csr_write.data[0];
            REG_OUTPUT_POST:    output_post_in    = csr_write.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cmd.echo      = 1'b0;
      cmd.echo_cr   = output_post_ff && (req_chan.data_byte == BYTE_NL);
      cmd.raw       = 1'b0;
      cmd.store     = 1'b0;
      cmd.rel       = 1'b0;
      cmd.data_byte = req_chan.data_byte;
      cmd.addr      = fill_ff;
      fill_in       = fill_ff;
      priority if (req_chan.operation == OP_PROG) begin
         cmd.echo = 1'b1;
      end else if (!canonical_mode_ff) begin
         cmd.echo = echo_enable_ff;
         cmd.raw  = 1'b1;
      end else if (req_chan.data_byte == BYTE_BS && fill_ff != '0) begin
         cmd.echo = echo_enable_ff;
         fill_in  = fill_ff - ADDR_W'(1);
      end else if (req_chan.data_byte == BYTE_CR) begin
         cmd.echo = echo_enable_ff;
         cmd.rel  = 1'b1;
         fill_in  = '0;
      end else if (fill_ff >= ADDR_W'(LINE_DEPTH - 1)) begin
         // line full: drop the byte and close the line
         cmd.rel = 1'b1;
         fill_in = '0;
      end else begin
         cmd.echo  = echo_enable_ff;
         cmd.store = 1'b1;
         fill_in   = fill_ff + ADDR_W'(1);
      end
   end

   assign queue_push = accept && (cmd.echo || cmd.raw || cmd.store || cmd.rel);
   assign queue_cmd  = cmd;

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_enable_ff    <= 1'b1;
         canonical_mode_ff <= 1'b1;
         output_post_ff    <= 1'b1;
         fill_ff           <= '0;
      end else begin
         echo_enable_ff    <= echo_enable_in;
         canonical_mode_ff <= canonical_mode_in;
         output_post_ff    <= output_post_in;
         if (accept) begin
            fill_ff <= fill_in;
         end
      end
   end

endmodule

FILE: src/tld_queue.sv
// Command queue between front end and back end.
module tld_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tld_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output tld_pkg::cmd_type head_cmd
);
   import tld_pkg::*;

   cmd_type           entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign full       = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + QPTR_W'(1);
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: src/tld_back.sv
// Back end: owns the line store, sequences echo, pass-through and line release.
module tld_back (
   input  logic             clock,
   input  logic             reset,
   input  logic             head_valid,
   input  tld_pkg::cmd_type head_cmd,
   output logic             pop,
   tld_rsp_if.source        rsp_chan
);
   import tld_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE      = 8'b0000_0001,
      ST_ECHO_CR   = 8'b0000_0010,
      ST_ECHO      = 8'b0000_0100,
      ST_RAW       = 8'b0000_1000,
      ST_REL_CR    = 8'b0001_0000,
      ST_REL_NL    = 8'b0010_0000,
      ST_REL_FETCH = 8'b0100_0000,
      ST_REL_DATA  = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   cmd_type           cmd_ff, cmd_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [BYTE_W-1:0] line_store_ff [LINE_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;
   logic              mem_we, rd_en;
   logic [BYTE_W-1:0] mem_wdata;
   logic              out_valid_ff, out_valid_in;
   logic              out_channel_ff, out_channel_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;
   logic              out_free;

   assign out_free  = !out_valid_ff || rsp_chan.ready;
   assign mem_wdata = head_cmd.store ? head_cmd.data_byte : BYTE_NL;

   always_comb begin
      state_in       = state_ff;
      cmd_in         = cmd_ff;
      idx_in         = idx_ff;
      pop            = 1'b0;
      mem_we         = 1'b0;
      rd_en          = 1'b0;
      out_valid_in   = out_valid_ff && !rsp_chan.ready;
      out_channel_in = out_channel_ff;
      out_byte_in    = out_byte_ff;
      out_last_in    = out_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head_valid) begin
               pop    = 1'b1;
               cmd_in = head_cmd;
               idx_in = '0;
               mem_we = head_cmd.store || head_cmd.rel;
               priority if (head_cmd.echo && head_cmd.echo_cr) state_in = ST_ECHO_CR;
               else if (head_cmd.echo) state_in = ST_ECHO;
               else if (head_cmd.raw)  state_in = ST_RAW;
               else if (head_cmd.rel)  state_in = ST_REL_CR;
               else                    state_in = ST_IDLE;
            end
         end
         ST_ECHO_CR: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_channel_in = CH_TERM;
               out_byte_in    = BYTE_CR;
               out_last_in    = 1'b0;
               state_in       = ST_ECHO;
            end
         end
         ST_ECHO: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_channel_in = CH_TERM;
               out_byte_in    = cmd_ff.data_byte;
               out_last_in    = !cmd_ff.raw && !cmd_ff.rel;
               priority if (cmd_ff.raw) state_in = ST_RAW;
               else if (cmd_ff.rel)     state_in = ST_REL_CR;
               else                     state_in = ST_IDLE;
            end
         end
         ST_RAW: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_channel_in = CH_PROG;
               out_byte_in    = cmd_ff.data_byte;
               out_last_in    = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         ST_REL_CR: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_channel_in = CH_TERM;
               out_byte_in    = BYTE_CR;
               out_last_in    = 1'b0;
               state_in       = ST_REL_NL;
            end
         end
         ST_REL_NL: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_channel_in = CH_TERM;
               out_byte_in    = BYTE_NL;
               out_last_in    = 1'b0;
               state_in       = ST_REL_FETCH;
            end
         end
         ST_REL_FETCH: begin
            rd_en    = 1'b1;
            state_in = ST_REL_DATA;
         end
         ST_REL_DATA: begin
            if (out_free) begin
               out_valid_in   = 1'b1;
               out_channel_in = CH_PROG;
               out_byte_in    = rdata_ff;
               out_last_in    = (idx_ff == cmd_ff.addr);
               if (idx_ff == cmd_ff.addr) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in   = idx_ff + ADDR_W'(1);
                  state_in = ST_REL_FETCH;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         line_store_ff[head_cmd.addr] <= mem_wdata;
      end
      if (rd_en) begin
         rdata_ff <= line_store_ff[idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      idx_ff         <= idx_in;
      out_channel_ff <= out_channel_in;
      out_byte_ff    <= out_byte_in;
      out_last_ff    <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.channel     = out_channel_ff;
   assign rsp_chan.out_byte    = out_byte_ff;
   assign rsp_chan.last_result = out_last_ff;

endmodule

FILE: src/tty_line_discipline_top.sv
// Top level of the terminal line discipline.
//
// req_chan carries one byte per transaction: operation 0 is a byte typed on the
// terminal side, 1 a byte written by the program side. rsp_chan returns the
// resulting bytes, channel 0 towards the terminal display, 1 towards the program,
// with last_result set on the final byte caused by each request. A request that
// causes nothing (edits with echo off) yields no transaction.
// csr_write_enable/csr_index/csr_write_data set echo_enable (0), canonical_mode (1)
// and output_post (2); write them only while the block is idle.
// A request that causes anything enters a 4-entry command queue the cycle it is
// taken. The back end pops one command while idle, then sends each echoed or
// passed byte through its output register; a line release sends CR and NL, then
// reads each buffered byte from the line store and registers it before sending it.
// Reset (synchronous) empties the queue and the line and sets all three modes on.
// When rsp_chan stalls the output register holds; requests are still taken until
// the command queue fills.
module tty_line_discipline_top (
   input  logic                               clock,
   input  logic                               reset,
   tld_req_if.sink                            req_chan,
   tld_rsp_if.source                          rsp_chan,
   input  logic                               csr_write_enable,
   input  logic [tld_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [tld_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import tld_pkg::*;

   csr_write_type csr_write;
   logic          queue_push, queue_full, queue_pop, head_valid;
   cmd_type       push_cmd, head_cmd;

   assign csr_write.write_enable = csr_write_enable;
   assign csr_write.index        = csr_index;
   assign csr_write.data         = csr_write_data;

   tld_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .csr_write  (csr_write),
      .queue_full (queue_full),
      .queue_push (queue_push),
      .queue_cmd  (push_cmd)
   );

   tld_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop        (queue_pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   tld_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (queue_pop),
      .rsp_chan   (rsp_chan)
   );

endmodule

FILE: tb/tty_line_discipline_top_tb.sv
// Self-checking testbench of the terminal line discipline: line editing, raw mode, output.
module tty_line_discipline_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tld_pkg::*;

   localparam int CYCLE_LIMIT    = 600000;
   localparam int SETTLE_CYCLES  = 40;
   localparam int HOLDOFF_CYCLES = 150;
   localparam logic [CSR_INDEX_W-1:0] REG_UNUSED = 2'd3;
   localparam logic [BYTE_W-1:0] PRINT_LO = 8'h20;
   localparam logic [BYTE_W-1:0] PRINT_HI = 8'h7E;

   typedef struct packed {
      logic              channel;
      logic [BYTE_W-1:0] out_byte;
      logic              last_result;
   } rsp_beat_type;

   logic clock = 1'b0;
   logic reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   tld_req_if req_chan();
   tld_rsp_if rsp_chan();

   tty_line_discipline_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Predicted line discipline state
   logic [BYTE_W-1:0] pred_line [LINE_DEPTH];
   int                line_len = 0;
   logic              echo_on  = 1'b1;
   logic              canon_on = 1'b1;
   logic              post_on  = 1'b1;

   rsp_beat_type step_beats [$];
   rsp_beat_type pending_bytes [$];
   rsp_beat_type want_beat;

   int   send_idle_pct = 0;
   int   recv_idle_pct = 0;
   int   holdoff_left  = 0;
   logic holdoff_req   = 1'b0;
   int   error_count   = 0;
   int   cycle_count   = 0;

   initial forever #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("TEST FAILED");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (holdoff_req) begin
         holdoff_left = HOLDOFF_CYCLES;
         holdoff_req  = 1'b0;
      end
      if (holdoff_left > 0) begin
         rsp_chan.ready <= 1'b0;
         holdoff_left--;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic report_mismatch(input string what, input int want, input int got);
      $display("cycle %0d: %s: expected %0h, got %0h", cycle_count, what, want, got);
      error_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_bytes.size() == 0) begin
            report_mismatch("result transaction with nothing expected", -1,
                            int'(rsp_chan.out_byte));
         end else begin
            want_beat = pending_bytes.pop_front();
            if (rsp_chan.channel !== want_beat.channel)
               report_mismatch("channel", int'(want_beat.channel),
                               int'(rsp_chan.channel));
            if (rsp_chan.out_byte !== want_beat.out_byte)
               report_mismatch("out_byte", int'(want_beat.out_byte),
                               int'(rsp_chan.out_byte));
            if (rsp_chan.last_result !== want_beat.last_result)
               report_mismatch("last_result", int'(want_beat.last_result),
                               int'(rsp_chan.last_result));
         end
      end
   end

   task automatic emit(input logic ch, input logic [BYTE_W-1:0] b);
      rsp_beat_type beat;
      beat.channel     = ch;
      beat.out_byte    = b;
      beat.last_result = 1'b0;
      step_beats.push_back(beat);
   endtask

   task automatic emit_display(input logic [BYTE_W-1:0] b);
      if (post_on && b == BYTE_NL) begin
         emit(CH_TERM, BYTE_CR);
         emit(CH_TERM, BYTE_NL);
      end else begin
         emit(CH_TERM, b);
      end
   endtask

   task automatic emit_line_end();
      pred_line[line_len] = BYTE_NL;
      line_len++;
      emit(CH_TERM, BYTE_CR);
      emit(CH_TERM, BYTE_NL);
      for (int i = 0; i < line_len; i++)
         emit(CH_PROG, pred_line[i]);
      line_len = 0;
   endtask

   task automatic apply_line_discipline(input logic op, input logic [BYTE_W-1:0] b);
      step_beats.delete();
      if (op == OP_PROG) begin
         emit_display(b);
      end else if (!canon_on) begin
         if (echo_on) emit_display(b);
         emit(CH_PROG, b);
      end else if (b == BYTE_BS && line_len > 0) begin
         if (echo_on) emit_display(b);
         line_len--;
      end else if (b == BYTE_CR) begin
         if (echo_on) emit_display(b);
         emit_line_end();
      end else if (line_len >= LINE_DEPTH - 1) begin
         // full line: byte dropped, line closed
         emit_line_end();
      end else begin
         if (echo_on) emit_display(b);
         pred_line[line_len] = b;
         line_len++;
      end
      if (step_beats.size() > 0)
         step_beats[step_beats.size() - 1].last_result = 1'b1;
      foreach (step_beats[i])
         pending_bytes.push_back(step_beats[i]);
   endtask

   // Called and returns at a falling edge; leaves valid high for back-to-back items
   task automatic send_byte(input logic op, input logic [BYTE_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.data_byte <= b;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      apply_line_discipline(op, b);
      @(negedge clock);
   endtask

   task automatic type_text(input string s);
      for (int i = 0; i < s.len(); i++)
         send_byte(OP_TERM, s[i]);
   endtask

   task automatic wait_idle();
      req_chan.valid <= 1'b0;
      while (pending_bytes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      case (idx)
         REG_ECHO_ENABLE:    echo_on  = val[0];
         REG_CANONICAL_MODE: canon_on = val[0];
         REG_OUTPUT_POST:    post_on  = val[0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_modes(input logic echo, input logic canon, input logic post);
      wait_idle();
      write_reg(REG_ECHO_ENABLE, echo);
      write_reg(REG_CANONICAL_MODE, canon);
      write_reg(REG_OUTPUT_POST, post);
   endtask

   task automatic test_canonical_editing();
      set_modes(1'b1, 1'b1, 1'b1);
      type_text("ab");
      send_byte(OP_TERM, BYTE_BS);
      send_byte(OP_TERM, BYTE_BS);
      send_byte(OP_TERM, BYTE_BS);   // empty line: kept as data
      send_byte(OP_TERM, BYTE_NL);   // ordinary byte here
      send_byte(OP_TERM, 8'h00);
      send_byte(OP_TERM, 8'hFF);
      send_byte(OP_TERM, BYTE_CR);
      set_modes(1'b0, 1'b1, 1'b1);
      type_text("q");
      send_byte(OP_TERM, BYTE_BS);
      send_byte(OP_TERM, BYTE_CR);
   endtask

   task automatic test_program_output();
      set_modes(1'b0, 1'b0, 1'b1);
      send_byte(OP_PROG, BYTE_NL);
      send_byte(OP_PROG, 8'h00);
      send_byte(OP_PROG, 8'hFF);
      send_byte(OP_PROG, BYTE_CR);
      set_modes(1'b1, 1'b1, 1'b0);
      send_byte(OP_PROG, BYTE_NL);
   endtask

   task automatic test_raw_mode();
      set_modes(1'b1, 1'b1, 1'b1);
      type_text("x");
      set_modes(1'b1, 1'b0, 1'b0);   // buffered line must survive
      send_byte(OP_TERM, BYTE_NL);
      send_byte(OP_TERM, BYTE_BS);
      send_byte(OP_TERM, 8'hFF);
      set_modes(1'b0, 1'b0, 1'b1);
      write_reg(REG_UNUSED, 1'b1);
      type_text("y");
      set_modes(1'b1, 1'b1, 1'b1);
      send_byte(OP_TERM, BYTE_CR);
   endtask

   task automatic test_full_line();
      set_modes(1'b1, 1'b1, 1'b1);
      send_byte(OP_TERM, BYTE_CR);
      for (int i = 0; i < LINE_DEPTH - 1; i++)
         send_byte(OP_TERM, 8'($urandom_range(PRINT_HI, PRINT_LO)));
      type_text("Z");
   endtask

   task automatic test_backpressure();
      set_modes(1'b1, 1'b1, 1'b1);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      holdoff_req   = 1'b1;
      for (int i = 0; i < 24; i++)
         send_byte(OP_TERM, 8'($urandom_range(PRINT_HI, PRINT_LO)));
      send_byte(OP_TERM, BYTE_CR);
   endtask

   task automatic random_traffic(input int n);
      int sent;
      int kind;
      int len;
      logic [BYTE_W-1:0] b;
      sent = 0;
      while (sent < n) begin
         kind = $urandom_range(99);
         if (kind < 65) begin
            // edited line ended by CR, now and then long enough to overflow
            len = ($urandom_range(9) == 0) ? $urandom_range(34, 28) : $urandom_range(8);
            for (int i = 0; i < len; i++) begin
               b = ($urandom_range(6) == 0) ? BYTE_BS : 8'($urandom_range(PRINT_HI, PRINT_LO));
               send_byte(OP_TERM, b);
            end
            send_byte(OP_TERM, BYTE_CR);
            sent += len + 1;
         end else if (kind < 85) begin
            b = ($urandom_range(3) == 0) ? BYTE_NL : 8'($urandom);
            send_byte(OP_PROG, b);
            sent++;
         end else begin
            send_byte(OP_TERM, 8'($urandom));
            sent++;
         end
      end
   endtask

   task automatic test_random_traffic();
      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin send_idle_pct = 6;  recv_idle_pct = 66; end
            1: begin send_idle_pct = 66; recv_idle_pct = 6;  end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         for (int s = 0; s < 4; s++) begin
            case (s)
               0: set_modes(1'b1, 1'b1, 1'b1);
               1: set_modes(1'b0, 1'b0, 1'b0);
               default: set_modes(1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
            endcase
            random_traffic(25);
         end
      end
   endtask

   initial begin
      reset              = 1'b1;
      req_chan.valid     = 1'b0;
      req_chan.operation = OP_TERM;
      req_chan.data_byte = '0;
      rsp_chan.ready     = 1'b0;
      csr_write_enable   = 1'b0;
      csr_index          = REG_ECHO_ENABLE;
      csr_write_data     = '0;
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 6;
      recv_idle_pct = 66;
      test_canonical_editing();
      test_program_output();
      test_raw_mode();
      test_full_line();
      test_backpressure();
      test_random_traffic();

      wait_idle();
      if (pending_bytes.size() != 0)
         report_mismatch("results never delivered", 0, pending_bytes.size());
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
